// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define DTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also holds across reset.
`define DTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dtt_pkg.sv =====
package dtt_pkg;

    // Field widths.
    localparam int FUNC_W     = 2;
    localparam int HANDLE_W   = 8;
    localparam int DELAY_W    = 16;
    localparam int NOW_W      = 64;
    localparam int KIND_W     = 3;
    localparam int WAIT_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Results one request may report.
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = 1'd1;
    localparam logic [WAIT_W-1:0]    MAX_WAIT_RST = 10'd50;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 2'd0,
        FN_SCHED  = 2'd1,
        FN_CANCEL = 2'd2,
        FN_WAKE   = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KD_RESUMED   = 3'd0,
        KD_CANCELLED = 3'd1,
        KD_IDLE      = 3'd2,
        KD_ACCEPTED  = 3'd3,
        KD_FULL      = 3'd4,
        KD_IGNORED   = 3'd5,
        KD_DONE      = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FIN
    } t_state;

    // Broadcast controls for the slot chain.
    typedef struct packed {
        logic shift;
        logic wake;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/dtt_cell.sv =====
module dtt_cell (
    input  logic                          i_clk,
    input  dtt_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_load,
    input  logic [dtt_pkg::HANDLE_W-1:0]  i_wr_handle,
    input  logic [dtt_pkg::NOW_W-1:0]     i_wr_deadline,
    input  logic [dtt_pkg::NOW_W-1:0]     i_now,
    input  logic [dtt_pkg::HANDLE_W-1:0]  i_nb_handle,
    input  logic [dtt_pkg::NOW_W-1:0]     i_nb_deadline,
    output logic [dtt_pkg::HANDLE_W-1:0]  o_handle,
    output logic [dtt_pkg::NOW_W-1:0]     o_deadline
);

    logic [dtt_pkg::HANDLE_W-1:0] r_handle;
    logic [dtt_pkg::NOW_W-1:0]    r_deadline;
    logic [dtt_pkg::HANDLE_W-1:0] n_handle;
    logic [dtt_pkg::NOW_W-1:0]    n_deadline;

    // A direct write wins over the shift, the shift over a wake.
    always_comb begin
        n_handle   = r_handle;
        n_deadline = r_deadline;
        if (i_load) begin
            n_handle   = i_wr_handle;
            n_deadline = i_wr_deadline;
        end else if (i_ctl.shift) begin
            n_handle   = i_nb_handle;
            n_deadline = i_nb_deadline;
        end else if (i_ctl.wake) begin
            n_deadline = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle   <= n_handle;
        r_deadline <= n_deadline;
    end

    assign o_handle   = r_handle;
    assign o_deadline = r_deadline;

endmodule

// ===== hw/rtl/deadline_timer_table.sv =====
// Pending-timer table, kept in insertion order in a chain of slot cells.
// Input channel (i_in_valid / o_in_ready) takes one request: tick, schedule,
// cancel all or wake all. Output channel (o_out_valid / i_out_ready) gives
// the results of that request one at a time; o_last marks the final one.
// Configuration is a plain write port (enable, max wait) used while idle.
// Schedule and wake all: the single result is staged as pending and moves
// to the output register in ST_FIN once that is free; the next request can
// be taken in the cycle in which that result first shows as valid.
// Tick and cancel all: the chain moves one slot per cycle past its head
// while no result waits on a stalled receiver; the walk over the occupied
// slots runs in ST_SCAN, a tick that reports its wait passes ST_WAIT, and
// the final result leaves from ST_FIN.
// A new request is taken once the previous one has placed its final result
// in the output register. When the receiver holds i_out_ready low, the walk
// pauses at the next slot that produces a result and no result is lost.
// Synchronous reset clears the time, the slot count, the output register
// and the configuration (disabled, max wait 50); slot contents are not
// cleared and never read before being written.
module deadline_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dtt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dtt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dtt_pkg::FUNC_W-1:0]      i_func,
    input  logic [dtt_pkg::HANDLE_W-1:0]    i_handle_id,
    input  logic [dtt_pkg::DELAY_W-1:0]     i_delay_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dtt_pkg::KIND_W-1:0]      o_kind,
    output logic [dtt_pkg::HANDLE_W-1:0]    o_handle_out,
    output logic [dtt_pkg::WAIT_W-1:0]      o_wait_ms,
    output logic                            o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Control state.
    dtt_pkg::t_state              r_state, n_state;
    logic [dtt_pkg::NOW_W-1:0]    r_now, n_now;
    logic [CNT_W-1:0]             r_count, n_count;
    logic                         r_out_valid, n_out_valid;
    logic                         r_pend_v, n_pend_v;
    logic                         r_enable;
    logic [dtt_pkg::WAIT_W-1:0]   r_max_wait;

    // Request and result payload.
    dtt_pkg::t_func               r_mode, n_mode;
    logic [CNT_W-1:0]             r_left, n_left;
    logic [dtt_pkg::RES_W-1:0]    r_nres, n_nres;
    logic [dtt_pkg::NOW_W-1:0]    r_min, n_min;
    logic                         r_min_v, n_min_v;
    dtt_pkg::t_kind               r_pend_kind, n_pend_kind;
    logic [dtt_pkg::HANDLE_W-1:0] r_pend_handle, n_pend_handle;
    logic [dtt_pkg::WAIT_W-1:0]   r_pend_wait, n_pend_wait;
    dtt_pkg::t_kind               r_out_kind, n_out_kind;
    logic [dtt_pkg::HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [dtt_pkg::WAIT_W-1:0]   r_out_wait, n_out_wait;
    logic                         r_out_last, n_out_last;

    // Chain signals.
    dtt_pkg::t_cell_ctl           cell_ctl;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_idx;
    logic [dtt_pkg::HANDLE_W-1:0] wr_handle;
    logic [dtt_pkg::NOW_W-1:0]    wr_deadline;
    logic [dtt_pkg::HANDLE_W-1:0] c_handle   [SLOTS];
    logic [dtt_pkg::NOW_W-1:0]    c_deadline [SLOTS];

    // Scratch values of the control block.
    logic                         out_free;
    logic [CNT_W-1:0]             cnt_m1;
    logic                         head_exp;
    logic                         emit;
    logic                         drop;
    logic [dtt_pkg::DELAY_W-1:0]  delay_eff;
    logic [dtt_pkg::NOW_W-1:0]    diff;
    logic [dtt_pkg::WAIT_W-1:0]   max_wait_eff;
    logic [dtt_pkg::WAIT_W-1:0]   wait_val;

    assign o_in_ready   = (r_state == dtt_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_handle_out = r_out_handle;
    assign o_wait_ms    = r_out_wait;
    assign o_last       = r_out_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_m1   = r_count - CNT_W'(1);

    // Slot chain: cell k takes from cell k+1 on a shift; cell 0 is the head.
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        logic [dtt_pkg::HANDLE_W-1:0] nb_handle;
        logic [dtt_pkg::NOW_W-1:0]    nb_deadline;

        if (k == SLOTS - 1) begin : g_tail
            assign nb_handle   = wr_handle;
            assign nb_deadline = wr_deadline;
        end else begin : g_mid
            assign nb_handle   = c_handle[k+1];
            assign nb_deadline = c_deadline[k+1];
        end

        dtt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_load        (wr_en && (wr_idx == IDX_W'(k))),
            .i_wr_handle   (wr_handle),
            .i_wr_deadline (wr_deadline),
            .i_now         (r_now),
            .i_nb_handle   (nb_handle),
            .i_nb_deadline (nb_deadline),
            .o_handle      (c_handle[k]),
            .o_deadline    (c_deadline[k])
        );
    end

    // Clamped wait until the earliest remaining deadline.
    always_comb begin
        max_wait_eff = (r_max_wait == '0) ? dtt_pkg::WAIT_W'(1) : r_max_wait;
        diff         = r_min - r_now;
        if (!r_min_v) begin
            wait_val = max_wait_eff;
        end else if (diff == '0) begin
            wait_val = dtt_pkg::WAIT_W'(1);
        end else if ((diff[dtt_pkg::NOW_W-1:dtt_pkg::WAIT_W] != '0)
                     || (diff[dtt_pkg::WAIT_W-1:0] > max_wait_eff)) begin
            wait_val = max_wait_eff;
        end else begin
            wait_val = diff[dtt_pkg::WAIT_W-1:0];
        end
    end

    // Next state, chain controls and result staging.
    always_comb begin
        n_state       = r_state;
        n_now         = r_now;
        n_count       = r_count;
        n_mode        = r_mode;
        n_left        = r_left;
        n_nres        = r_nres;
        n_min         = r_min;
        n_min_v       = r_min_v;
        n_pend_v      = r_pend_v;
        n_pend_kind   = r_pend_kind;
        n_pend_handle = r_pend_handle;
        n_pend_wait   = r_pend_wait;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_handle  = r_out_handle;
        n_out_wait    = r_out_wait;
        n_out_last    = r_out_last;
        cell_ctl      = '0;
        wr_en         = 1'b0;
        wr_idx        = r_count[IDX_W-1:0];
        wr_handle     = c_handle[0];
        wr_deadline   = c_deadline[0];
        delay_eff     = (i_delay_ms == '0) ? dtt_pkg::DELAY_W'(1) : i_delay_ms;
        head_exp      = (c_deadline[0] <= r_now)
                        && (r_nres < dtt_pkg::RES_W'(dtt_pkg::MAX_RESULTS));
        emit          = 1'b0;
        drop          = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            dtt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode        = dtt_pkg::t_func'(i_func);
                    n_nres        = '0;
                    n_min_v       = 1'b0;
                    n_left        = r_count;
                    n_pend_handle = '0;
                    n_pend_wait   = '0;
                    unique case (dtt_pkg::t_func'(i_func))
                        dtt_pkg::FN_TICK: begin
                            n_now   = r_now + dtt_pkg::NOW_W'(1);
                            n_state = dtt_pkg::ST_SCAN;
                        end
                        dtt_pkg::FN_CANCEL: begin
                            n_state = dtt_pkg::ST_SCAN;
                        end
                        dtt_pkg::FN_SCHED: begin
                            n_pend_v = 1'b1;
                            n_state  = dtt_pkg::ST_FIN;
                            if (!r_enable || (i_handle_id == '0)) begin
                                n_pend_kind = dtt_pkg::KD_IGNORED;
                            end else if (r_count >= CNT_W'(SLOTS)) begin
                                n_pend_kind = dtt_pkg::KD_FULL;
                            end else begin
                                n_pend_kind = dtt_pkg::KD_ACCEPTED;
                                wr_en       = 1'b1;
                                wr_handle   = i_handle_id;
                                wr_deadline = r_now
                                    + dtt_pkg::NOW_W'(delay_eff);
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        dtt_pkg::FN_WAKE: begin
                            cell_ctl.wake = 1'b1;
                            n_pend_v      = 1'b1;
                            n_pend_kind   = dtt_pkg::KD_DONE;
                            n_state       = dtt_pkg::ST_FIN;
                        end
                        default: begin
                            n_state = dtt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            dtt_pkg::ST_SCAN: begin
                if (r_left == '0) begin
                    // Walk finished: pick the final result.
                    if (r_pend_v) begin
                        n_state = dtt_pkg::ST_FIN;
                    end else if (r_mode == dtt_pkg::FN_CANCEL) begin
                        n_pend_v      = 1'b1;
                        n_pend_kind   = dtt_pkg::KD_DONE;
                        n_pend_handle = '0;
                        n_pend_wait   = '0;
                        n_state       = dtt_pkg::ST_FIN;
                    end else begin
                        n_state = dtt_pkg::ST_WAIT;
                    end
                end else begin
                    // Examine the head slot; it leaves or goes back behind the rest.
                    if (r_mode == dtt_pkg::FN_CANCEL) begin
                        drop = 1'b1;
                        emit = (r_nres < dtt_pkg::RES_W'(dtt_pkg::MAX_RESULTS));
                    end else begin
                        drop = head_exp;
                        emit = head_exp;
                    end
                    if (!(emit && r_pend_v && !out_free)) begin
                        cell_ctl.shift = 1'b1;
                        n_left         = r_left - CNT_W'(1);
                        if (drop) begin
                            n_count = cnt_m1;
                        end else begin
                            wr_en  = 1'b1;
                            wr_idx = cnt_m1[IDX_W-1:0];
                            if (!r_min_v || (c_deadline[0] < r_min)) begin
                                n_min   = c_deadline[0];
                                n_min_v = 1'b1;
                            end
                        end
                        if (emit) begin
                            if (r_pend_v) begin
                                n_out_valid  = 1'b1;
                                n_out_kind   = r_pend_kind;
                                n_out_handle = r_pend_handle;
                                n_out_wait   = r_pend_wait;
                                n_out_last   = 1'b0;
                            end
                            n_pend_v      = 1'b1;
                            n_pend_kind   = (r_mode == dtt_pkg::FN_CANCEL)
                                            ? dtt_pkg::KD_CANCELLED
                                            : dtt_pkg::KD_RESUMED;
                            n_pend_handle = c_handle[0];
                            n_pend_wait   = '0;
                            n_nres        = r_nres + dtt_pkg::RES_W'(1);
                        end
                    end
                end
            end

            dtt_pkg::ST_WAIT: begin
                n_pend_v      = 1'b1;
                n_pend_kind   = dtt_pkg::KD_IDLE;
                n_pend_handle = '0;
                n_pend_wait   = wait_val;
                n_state       = dtt_pkg::ST_FIN;
            end

            dtt_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_handle = r_pend_handle;
                    n_out_wait   = r_pend_wait;
                    n_out_last   = 1'b1;
                    n_pend_v     = 1'b0;
                    n_state      = dtt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = dtt_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
            r_enable    <= 1'b0;
            r_max_wait  <= dtt_pkg::MAX_WAIT_RST;
        end else begin
            r_now       <= n_now;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend_v    <= n_pend_v;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dtt_pkg::CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                    dtt_pkg::CFG_MAX_WAIT: r_max_wait <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_left        <= n_left;
        r_nres        <= n_nres;
        r_min         <= n_min;
        r_min_v       <= n_min_v;
        r_pend_kind   <= n_pend_kind;
        r_pend_handle <= n_pend_handle;
        r_pend_wait   <= n_pend_wait;
        r_out_kind    <= n_out_kind;
        r_out_handle  <= n_out_handle;
        r_out_wait    <= n_out_wait;
        r_out_last    <= n_out_last;
    end

endmodule

// ===== hw/rtl/dtt_checker.sv =====
`include "assert_macros.svh"

module dtt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [dtt_pkg::KIND_W-1:0]    o_kind,
    input logic [dtt_pkg::HANDLE_W-1:0]  o_handle_out,
    input logic [dtt_pkg::WAIT_W-1:0]    o_wait_ms
);

    // A stalled result stays put.
    `DTT_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_handle_out), "result changed while stalled")

    // Reset empties the output register.
    `DTT_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // One request at a time: taking a request closes the input.
    `DTT_ASSERT(a_one_req, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "request taken while busy")

    // Only resumed and cancelled results carry a handle.
    `DTT_ASSERT(a_handle_kind, i_clk, i_rst_n, o_out_valid && (o_kind != dtt_pkg::KD_RESUMED) && (o_kind != dtt_pkg::KD_CANCELLED) |-> o_handle_out == '0, "handle on wrong kind")

    // An idle result always reports a wait of at least one.
    `DTT_ASSERT(a_idle_wait, i_clk, i_rst_n, o_out_valid && (o_kind == dtt_pkg::KD_IDLE) |-> o_wait_ms != '0, "idle result with zero wait")

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_handle_out (o_handle_out),
    .o_wait_ms    (o_wait_ms)
);
